// ===== sv/lblt_pkg.sv =====
package lblt_pkg;

    localparam int MAX_LINES  = 32;
    localparam int COORD_BITS = 12;

    localparam int LINE_W  = $clog2(MAX_LINES);
    localparam int LC_W    = $clog2(MAX_LINES + 1);
    localparam int DX_W    = COORD_BITS + 1;
    localparam int DY_W    = COORD_BITS + 2;
    localparam int D2_W    = 2 * DY_W;
    localparam int SQ_W    = 20;
    localparam int PADDR_W = 4;

    // size filter and distance limits
    localparam int WIDTH_MIN_DIV = 25;
    localparam int WIDTH_MAX_DIV = 5;
    localparam int HEIGHT_SLACK  = 10;
    localparam int NEAR_ROWS     = 2;
    localparam int GAP_ROWS      = 4;

    localparam logic [1:0] OUT_NEAR = 2'd0;
    localparam logic [1:0] OUT_GAP  = 2'd1;
    localparam logic [1:0] OUT_NEW  = 2'd2;
    localparam logic [1:0] OUT_FULL = 2'd3;

    localparam logic [1:0] REG_FRAME_COLS = 2'd0;
    localparam logic [1:0] REG_FRAME_ROWS = 2'd1;
    localparam logic [1:0] REG_ROW_HEIGHT = 2'd2;

    localparam logic [11:0] FRAME_COLS_RST = 12'd640;
    localparam logic [11:0] FRAME_ROWS_RST = 12'd480;
    localparam logic [7:0]  ROW_HEIGHT_RST = 8'd20;

    typedef logic [LINE_W-1:0] t_line;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic signed [COORD_BITS:0] y;
    } t_tail;

    typedef struct packed {
        logic  valid;
        t_line idx;
    } t_dist_tag;

    typedef struct packed {
        logic            valid;
        t_line           idx;
        logic [D2_W-1:0] d2;
    } t_dist_res;

endpackage

// ===== sv/lblt_tail_ram.sv =====
module lblt_tail_ram (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  lblt_pkg::t_line      i_waddr,
    input  lblt_pkg::t_tail      i_wdata,
    input  logic                 i_re,
    input  lblt_pkg::t_line      i_raddr,
    output lblt_pkg::t_tail      o_rdata
);
    import lblt_pkg::*;

    t_tail r_mem [MAX_LINES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/lblt_dist.sv =====
module lblt_dist (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lblt_pkg::t_dist_tag                  i_tag,
    input  lblt_pkg::t_tail                      i_tail,
    input  logic [lblt_pkg::COORD_BITS-1:0]      i_cx,
    input  logic signed [lblt_pkg::COORD_BITS:0] i_cy,
    output lblt_pkg::t_dist_res                  o_res
);
    import lblt_pkg::*;

    logic signed [DX_W-1:0]   s_dx;
    logic signed [DY_W-1:0]   s_dy;
    logic signed [2*DX_W-1:0] s_dx2;
    logic signed [2*DY_W-1:0] s_dy2;
    logic [2*DX_W-1:0]        r_dx2;
    logic [2*DY_W-1:0]        r_dy2;
    t_dist_tag                r_tag;

    assign s_dx  = $signed({1'b0, i_cx}) - $signed({1'b0, i_tail.x});
    assign s_dy  = $signed({i_cy[COORD_BITS], i_cy}) -
                   $signed({i_tail.y[COORD_BITS], i_tail.y});
    assign s_dx2 = s_dx * s_dx;
    assign s_dy2 = s_dy * s_dy;

    // square stage, then sum stage
    always_ff @(posedge i_clk) begin
        r_dx2 <= $unsigned(s_dx2);
        r_dy2 <= $unsigned(s_dy2);
        r_tag.idx <= i_tag.idx;
        o_res.idx <= r_tag.idx;
        o_res.d2  <= D2_W'(r_dx2) + D2_W'(r_dy2);
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
            o_res.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
            o_res.valid <= r_tag.valid;
        end
    end

endmodule

// ===== sv/lane_blob_line_tracker.sv =====
// An accepted item goes through the centre and size-filter step, a search in which the tail
// memory port reads each stored line (counted after any frame-start clear) at one per cycle
// into the distance unit, and a decision step; the search is skipped when no line is stored,
// and a box dropped by the size filter returns to idle. A new item is taken only in idle.
// Result stalls hold the decision step and the input. Reset (synchronous, active low)
// restores register defaults, clears line count, broken marks and handshakes, not tails.
module lane_blob_line_tracker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lblt_pkg::PADDR_W-1:0]           paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    input  logic                                   i_box_valid,
    output logic                                   o_box_ready,
    input  logic                                   i_frame_start,
    input  logic [7:0]                             i_strip_index,
    input  logic [11:0]                            i_box_x,
    input  logic [7:0]                             i_box_y,
    input  logic [11:0]                            i_box_width,
    input  logic [7:0]                             i_box_height,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output logic [lblt_pkg::LINE_W-1:0]            o_line_number,
    output logic [lblt_pkg::COORD_BITS-1:0]        o_centre_x,
    output logic signed [lblt_pkg::COORD_BITS:0]   o_centre_y,
    output logic [1:0]                             o_outcome,
    output logic                                   o_line_broken
);
    import lblt_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    localparam int CY_W     = 19;
    localparam int CX_SUM_W = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
    localparam int FW       = 17;

    localparam logic signed [CY_W-1:0] CY_LO = CY_W'(-(2 ** COORD_BITS));
    localparam logic signed [CY_W-1:0] CY_HI = CY_W'(2 ** COORD_BITS - 1);
    localparam logic [CX_SUM_W-1:0]    CX_HI = CX_SUM_W'(2 ** COORD_BITS - 1);

    // configuration
    logic [11:0] r_fc;
    logic [11:0] r_fr;
    logic [7:0]  r_rh;
    logic        s_cfg_wr;

    // control
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [LC_W-1:0]       r_line_cnt;
    logic [MAX_LINES-1:0]  r_broken;
    logic [LC_W-1:0]       r_rd_idx;
    logic                  r_issue;
    t_dist_tag             r_rd_tag;
    t_line                 r_best;
    logic [D2_W-1:0]       r_best_d2;

    // item
    logic [7:0]  r_k;
    logic [11:0] r_bx;
    logic [7:0]  r_by;
    logic [11:0] r_bw;
    logic [7:0]  r_bh;
    logic [COORD_BITS-1:0]      r_cx;
    logic signed [COORD_BITS:0] r_cy;
    logic [SQ_W-1:0]            r_near2;
    logic [SQ_W-1:0]            r_gap2;

    // result register
    logic                       r_res_valid;
    t_line                      r_res_line;
    logic [COORD_BITS-1:0]      r_res_cx;
    logic signed [COORD_BITS:0] r_res_cy;
    logic [1:0]                 r_res_outcome;
    logic                       r_res_brk;

    logic                       s_accept;
    logic                       s_keep;
    logic [15:0]                s_kxrh;
    logic [15:0]                s_rh_sq;
    logic [FW-1:0]              s_bw_lo;
    logic [FW-1:0]              s_bw_hi;
    logic [CX_SUM_W-1:0]        s_cx_sum;
    logic signed [CY_W-1:0]     s_cy_sum;
    logic [COORD_BITS-1:0]      s_cx;
    logic signed [COORD_BITS:0] s_cy;
    logic                       s_last_issue;
    logic                       s_last_dist;
    logic                       s_load;
    logic                       s_hit;
    logic                       s_near;
    logic                       s_full;
    logic                       s_we;
    t_line                      s_waddr;
    t_tail                      s_wdata;
    t_line                      s_line;
    logic [1:0]                 s_outcome;
    logic                       s_brk;
    t_tail                      w_tail;
    t_dist_res                  w_dist;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc <= FRAME_COLS_RST;
            r_fr <= FRAME_ROWS_RST;
            r_rh <= ROW_HEIGHT_RST;
        end else if (s_cfg_wr) begin
            unique case (paddr[3:2])
                REG_FRAME_COLS: r_fc <= pwdata[11:0];
                REG_FRAME_ROWS: r_fr <= pwdata[11:0];
                REG_ROW_HEIGHT: r_rh <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_COLS: prdata = 32'(r_fc);
            REG_FRAME_ROWS: prdata = 32'(r_fr);
            REG_ROW_HEIGHT: prdata = 32'(r_rh);
            default:        prdata = '0;
        endcase
    end

    // ---------------- centre and filter ----------------
    assign s_accept = i_box_valid && o_box_ready;
    assign s_kxrh   = 16'(r_k) * 16'(r_rh);
    assign s_rh_sq  = 16'(r_rh) * 16'(r_rh);

    // bw > fc/25, bw < fc/5 and bh + HEIGHT_SLACK > rh without dividing
    assign s_bw_lo = FW'(r_bw) * FW'(WIDTH_MIN_DIV);
    assign s_bw_hi = (FW'(r_bw) + FW'(1)) * FW'(WIDTH_MAX_DIV);
    assign s_keep  = (FW'(r_fc) < s_bw_lo) && (s_bw_hi <= FW'(r_fc)) &&
                     (9'(r_bh) + 9'(HEIGHT_SLACK) > 9'(r_rh));

    assign s_cx_sum = CX_SUM_W'(r_bx) + CX_SUM_W'(r_bw[11:1]);
    assign s_cx     = (s_cx_sum > CX_HI) ? CX_HI[COORD_BITS-1:0]
                                         : s_cx_sum[COORD_BITS-1:0];
    assign s_cy_sum = $signed(CY_W'(r_by)) + $signed(CY_W'(r_bh[7:1])) +
                      $signed(CY_W'(r_fr)) - $signed(CY_W'(s_kxrh));

    always_comb begin
        priority if (s_cy_sum < CY_LO) begin
            s_cy = CY_LO[COORD_BITS:0];
        end else if (s_cy_sum > CY_HI) begin
            s_cy = CY_HI[COORD_BITS:0];
        end else begin
            s_cy = s_cy_sum[COORD_BITS:0];
        end
    end

    // ---------------- search ----------------
    assign s_last_issue = (r_rd_idx == r_line_cnt - LC_W'(1));
    assign s_last_dist  = w_dist.valid &&
                          (LC_W'(w_dist.idx) == r_line_cnt - LC_W'(1));

    lblt_tail_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (r_issue),
        .i_raddr (r_rd_idx[LINE_W-1:0]),
        .o_rdata (w_tail)
    );

    lblt_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_tail  (w_tail),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_res   (w_dist)
    );

    // ---------------- decision ----------------
    assign s_hit  = (r_line_cnt != '0) && (r_best_d2 <= D2_W'(r_gap2));
    assign s_near = (r_best_d2 <= D2_W'(r_near2));
    assign s_full = (r_line_cnt == LC_W'(MAX_LINES));
    assign s_load = (r_state == ST_DECIDE) && (!r_res_valid || i_res_ready);

    always_comb begin
        s_wdata.x = r_cx;
        s_wdata.y = r_cy;
        priority if (s_hit) begin
            s_waddr   = r_best;
            s_line    = r_best;
            s_outcome = s_near ? OUT_NEAR : OUT_GAP;
            s_brk     = s_near ? r_broken[r_best] : 1'b1;
            s_we      = s_load;
        end else if (!s_full) begin
            s_waddr   = r_line_cnt[LINE_W-1:0];
            s_line    = r_line_cnt[LINE_W-1:0];
            s_outcome = OUT_NEW;
            s_brk     = 1'b0;
            s_we      = s_load;
        end else begin
            s_waddr   = r_best;
            s_line    = '0;
            s_outcome = OUT_FULL;
            s_brk     = 1'b0;
            s_we      = 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = ST_CALC;
            end
            ST_CALC: begin
                priority if (!s_keep) n_state = ST_IDLE;
                else if (r_line_cnt == '0) n_state = ST_DECIDE;
                else n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (s_last_dist) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (s_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_box_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_k  <= i_strip_index;
            r_bx <= i_box_x;
            r_by <= i_box_y;
            r_bw <= i_box_width;
            r_bh <= i_box_height;
        end
        if (r_state == ST_CALC) begin
            r_cx    <= s_cx;
            r_cy    <= s_cy;
            r_near2 <= SQ_W'(s_rh_sq) * SQ_W'(NEAR_ROWS * NEAR_ROWS);
            r_gap2  <= SQ_W'(s_rh_sq) * SQ_W'(GAP_ROWS * GAP_ROWS);
        end
        r_rd_tag.idx <= r_rd_idx[LINE_W-1:0];
        if (w_dist.valid && (w_dist.idx == '0 || w_dist.d2 < r_best_d2)) begin
            r_best    <= w_dist.idx;
            r_best_d2 <= w_dist.d2;
        end
        if (s_load) begin
            r_res_line    <= s_line;
            r_res_cx      <= r_cx;
            r_res_cy      <= r_cy;
            r_res_outcome <= s_outcome;
            r_res_brk     <= s_brk;
        end
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_line_cnt     <= '0;
            r_broken       <= '0;
            r_rd_idx       <= '0;
            r_issue        <= 1'b0;
            r_rd_tag.valid <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rd_tag.valid <= (r_state == ST_SEARCH) && r_issue;
            if (s_accept && i_frame_start) begin
                r_line_cnt <= '0;
                r_broken   <= '0;
            end
            if (r_state == ST_CALC) begin
                r_rd_idx <= '0;
                r_issue  <= s_keep && (r_line_cnt != '0);
            end else if (r_issue) begin
                r_rd_idx <= r_rd_idx + LC_W'(1);
                if (s_last_issue) r_issue <= 1'b0;
            end
            if (s_load) begin
                if (s_hit) begin
                    if (!s_near) r_broken[r_best] <= 1'b1;
                end else if (!s_full) begin
                    r_broken[r_line_cnt[LINE_W-1:0]] <= 1'b0;
                    r_line_cnt <= r_line_cnt + LC_W'(1);
                end
            end
            // hold the result until taken
            if (s_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_line_number = r_res_line;
    assign o_centre_x    = r_res_cx;
    assign o_centre_y    = r_res_cy;
    assign o_outcome     = r_res_outcome;
    assign o_line_broken = r_res_brk;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_cnt <= LC_W'(MAX_LINES))
        else $error("line count beyond table size");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_frame_start) |=> (r_line_cnt == '0 && r_broken == '0))
        else $error("frame start did not clear the table");

    a_new_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load |=> (r_res_outcome != OUT_NEW ||
                    r_line_cnt == LC_W'(r_res_line) + LC_W'(1)))
        else $error("new line index does not match line count");

    a_dist_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dist.valid |-> (r_state == ST_SEARCH))
        else $error("distance result outside search");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && r_res_valid && !i_res_ready) |=>
            (r_state == ST_DECIDE))
        else $error("result overwritten before taken");
`endif

endmodule
